FILE: hdl/msbm_pkg.sv
// Shared types and constants for the Manchester sensor bus master.
`default_nettype none
package msbm_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_WAIT = 2'd2,
		PH_RECV = 2'd3
	} phase_t;

	localparam logic [3:0] START_CODE = 4'b0110;
	localparam logic [3:0] FN_INFO    = 4'b0001;
	localparam logic [3:0] FN_DATA    = 4'b0010;

	typedef struct packed {
		logic       func;
		logic [3:0] sensor_address;
		logic [3:0] function_code;
		logic       line_in;
	} item_t;

	typedef struct packed {
		logic        line_out;
		logic        busy_res;
		logic        reply_done;
		logic        reply_ok;
		logic [3:0]  reply_address;
		logic [3:0]  reply_function;
		logic [3:0]  error_bits;
		logic [3:0]  sensor_type;
		logic [11:0] sensor_data;
	} result_t;

endpackage
`default_nettype wire

FILE: hdl/msbm_in_if.sv
// Input channel: one tick or start request per transfer.
`default_nettype none
interface msbm_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [3:0] sensor_address;
	logic [3:0] function_code;
	logic       line_in;

	modport source (output valid, output func, output sensor_address,
		output function_code, output line_in, input ready);
	modport sink (input valid, input func, input sensor_address,
		input function_code, input line_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/msbm_out_if.sv
// Result channel: line level, status and decoded reply per transfer.
`default_nettype none
interface msbm_out_if;
	logic        valid;
	logic        ready;
	logic        line_out;
	logic        busy_res;
	logic        reply_done;
	logic        reply_ok;
	logic [3:0]  reply_address;
	logic [3:0]  reply_function;
	logic [3:0]  error_bits;
	logic [3:0]  sensor_type;
	logic [11:0] sensor_data;

	modport source (output valid, output line_out, output busy_res, output reply_done,
		output reply_ok, output reply_address, output reply_function, output error_bits,
		output sensor_type, output sensor_data, input ready);
	modport sink (input valid, input line_out, input busy_res, input reply_done,
		input reply_ok, input reply_address, input reply_function, input error_bits,
		input sensor_type, input sensor_data, output ready);
endinterface
`default_nettype wire

FILE: hdl/msbm_core.sv
// Bus state machine: frame send, dead tick, reply capture and decode.
`default_nettype none
module msbm_core
	import msbm_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 12,
	parameter int unsigned REPLY_BITS = 24
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    accept,
	input  wire item_t   item,
	output result_t      result
);

	localparam int unsigned SEND_W = $clog2(2 * FRAME_BITS);
	localparam int unsigned RECV_W = $clog2(REPLY_BITS);
	localparam int unsigned CNT_W  = (SEND_W > RECV_W) ? SEND_W : RECV_W;
	localparam logic [CNT_W-1:0] SEND_LAST = CNT_W'(2 * FRAME_BITS - 1);
	localparam logic [CNT_W-1:0] RECV_LAST = CNT_W'(REPLY_BITS - 1);

	phase_t                  phase_q, phase_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [FRAME_BITS-1:0]   tx_q, tx_d;
	logic [REPLY_BITS-1:0]   rx_q, rx_d, rx_shifted;
	logic                    clk_tgl_q, clk_tgl_d;
	logic                    line_q, line_d;
	logic [3:0]              want_addr_q, want_addr_d;
	logic [3:0]              want_fn_q, want_fn_d;
	logic [FRAME_BITS+11:0]  frame_ext;
	logic                    tick, start, done, ok;
	logic [3:0]              r_addr, r_fn;

	assign tick       = accept && !item.func;
	assign start      = accept && item.func && (phase_q == PH_IDLE);
	assign rx_shifted = {rx_q[REPLY_BITS-2:0], item.line_in};
	assign frame_ext  = {{FRAME_BITS{1'b0}}, START_CODE, item.sensor_address,
		item.function_code};

	// next state
	always_comb begin
		phase_d = phase_q;
		if (start) begin
			phase_d = PH_SEND;
		end else if (tick) begin
			case (phase_q)
				PH_SEND: if (cnt_q == SEND_LAST) phase_d = PH_WAIT;
				PH_WAIT: phase_d = PH_RECV;
				PH_RECV: if (cnt_q == RECV_LAST) phase_d = PH_IDLE;
				default: phase_d = phase_q;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		cnt_d       = cnt_q;
		tx_d        = tx_q;
		rx_d        = rx_q;
		want_addr_d = want_addr_q;
		want_fn_d   = want_fn_q;
		clk_tgl_d   = tick ? ~clk_tgl_q : clk_tgl_q;
		line_d      = line_q;
		done        = 1'b0;
		if (start) begin
			cnt_d       = '0;
			tx_d        = frame_ext[FRAME_BITS-1:0];
			want_addr_d = item.sensor_address;
			want_fn_d   = item.function_code;
		end else if (tick) begin
			case (phase_q)
				PH_SEND: begin
					// inverted Manchester: 0 goes high then low
					line_d = ~(tx_q[FRAME_BITS-1] ^ cnt_q[0]);
					if (cnt_q[0]) tx_d = tx_q << 1;
					cnt_d = (cnt_q == SEND_LAST) ? '0 : cnt_q + 1'b1;
				end
				PH_WAIT: begin
					line_d = clk_tgl_d;
					cnt_d  = '0;
				end
				PH_RECV: begin
					line_d = clk_tgl_d;
					rx_d   = rx_shifted;
					done   = (cnt_q == RECV_LAST);
					cnt_d  = done ? '0 : cnt_q + 1'b1;
				end
				default: line_d = clk_tgl_d;
			endcase
		end
	end

	assign r_addr = rx_shifted[REPLY_BITS-1 -: 4];
	assign r_fn   = rx_shifted[REPLY_BITS-5 -: 4];
	assign ok     = (r_addr == want_addr_q) && (r_fn == want_fn_q);

	always_comb begin
		result                = '0;
		result.line_out       = line_d;
		result.busy_res       = (phase_d != PH_IDLE);
		result.reply_done     = done;
		if (done) begin
			result.reply_ok       = ok;
			result.reply_address  = r_addr;
			result.reply_function = r_fn;
			if (ok && (r_fn == FN_INFO || r_fn == FN_DATA))
				result.error_bits = rx_shifted[REPLY_BITS-9 -: 4];
			if (ok && r_fn == FN_INFO)
				result.sensor_type = rx_shifted[11:8];
			if (ok && r_fn == FN_DATA)
				result.sensor_data = rx_shifted[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			clk_tgl_q <= 1'b0;
			line_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			clk_tgl_q <= clk_tgl_d;
			line_q    <= line_d;
		end
	end

	always_ff @(posedge clk) begin
		tx_q        <= tx_d;
		rx_q        <= rx_d;
		want_addr_q <= want_addr_d;
		want_fn_q   <= want_fn_d;
	end

endmodule
`default_nettype wire

FILE: hdl/msbm_obuf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module msbm_obuf
	import msbm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         can_push,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_v_q, skid_v_q, pop;
	result_t main_q, skid_q;

	assign can_push  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign pop       = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !main_v_q) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/manchester_sensor_bus_master_top.sv
// Top level of the Manchester sensor bus master.
// Every transfer on req is either a tick (func = 0) or a start request (func = 1) and yields
// exactly one transfer on rsp. One item is taken per clock while req is ready: the bus state,
// counters and shift registers update in the cycle of acceptance, so the rate is set only by
// the two-entry result buffer, which keeps req ready while rsp stalls for one result. A start
// is honored only while idle; it sends 2*FRAME_BITS inverted Manchester half-bits on the
// following ticks, then one dead tick, then samples REPLY_BITS reply bits MSB first. The line
// carries a toggling clock on every tick outside the send phase.
`default_nettype none
module manchester_sensor_bus_master_top
	import msbm_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 12,
	parameter int unsigned REPLY_BITS = 24
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	msbm_in_if.sink     req,
	msbm_out_if.source  rsp
);

	logic    accept, can_push;
	item_t   item;
	result_t result, out_data;

	assign req.ready = can_push;
	assign accept    = req.valid && can_push;

	assign item.func           = req.func;
	assign item.sensor_address = req.sensor_address;
	assign item.function_code  = req.function_code;
	assign item.line_in        = req.line_in;

	msbm_core #(
		.FRAME_BITS(FRAME_BITS),
		.REPLY_BITS(REPLY_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.result(result)
	);

	msbm_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(result),
		.can_push (can_push),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_data (out_data)
	);

	assign rsp.line_out       = out_data.line_out;
	assign rsp.busy_res       = out_data.busy_res;
	assign rsp.reply_done     = out_data.reply_done;
	assign rsp.reply_ok       = out_data.reply_ok;
	assign rsp.reply_address  = out_data.reply_address;
	assign rsp.reply_function = out_data.reply_function;
	assign rsp.error_bits     = out_data.error_bits;
	assign rsp.sensor_type    = out_data.sensor_type;
	assign rsp.sensor_data    = out_data.sensor_data;

endmodule
`default_nettype wire
